// ----- rtl/core/lkst_pkg.sv -----
// Types and constants shared by the latency statistics table.
`default_nettype none

package lkst_pkg;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned RTT_W   = 32;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned TIME_W  = 64;
  localparam int unsigned MEAN_OW = 48;
  localparam int unsigned DIVR_W  = CNT_W + 1;

  localparam logic ACT_RECORD = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NOT_FOUND   = 2'd1,
    ST_TABLE_FULL  = 2'd2,
    ST_NOT_ENABLED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PREP,
    S_DIV,
    S_UPD,
    S_OUT
  } state_e;

  typedef struct packed {
    logic              action;
    logic [KEY_W-1:0]  server_id;
    logic [RTT_W-1:0]  rtt_ms;
    logic [TIME_W-1:0] time_ms;
  } lkst_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [RTT_W-1:0]   min_rtt;
    logic [RTT_W-1:0]   max_rtt;
    logic [MEAN_OW-1:0] mean_rtt;
    logic [RTT_W-1:0]   recent_rtt;
    logic [CNT_W-1:0]   sample_count;
    logic [TIME_W-1:0]  recent_time;
  } lkst_out_t;

endpackage

`default_nettype wire

// ----- rtl/core/lkst_store.sv -----
// Entry memory: one write port, one read port with registered read data.
`default_nettype none

module lkst_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 272,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold read data between reads.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/lkst_div.sv -----
// Serial restoring divider, one quotient bit per cycle.
`default_nettype none

module lkst_div import lkst_pkg::*; #(
  parameter int unsigned DW = 48
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DW-1:0]     dividend_i,
  input  wire logic [DIVR_W-1:0] divisor_i,
  output logic                   done_o,
  output logic      [DW-1:0]     quot_o
);

  localparam int unsigned CNTW = $clog2(DW + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNTW-1:0]   cnt_q, cnt_d;
  logic [DW-1:0]     quot_q, quot_d;
  logic [DIVR_W-1:0] rem_q, rem_d;
  logic [DIVR_W-1:0] div_q, div_d;
  logic [DIVR_W:0]   trial;
  logic [DIVR_W:0]   trial_sub;
  logic              fits;

  assign trial     = {rem_q, quot_q[DW-1]};
  assign fits      = trial >= {1'b0, div_q};
  assign trial_sub = trial - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNTW'(DW);
      quot_d = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      // Shift in the next dividend bit, subtract when the divisor fits.
      rem_d  = fits ? trial_sub[DIVR_W-1:0] : trial[DIVR_W-1:0];
      quot_d = {quot_q[DW-2:0], fits};
      cnt_d  = cnt_q - CNTW'(1);
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

// ----- rtl/core/per_key_latency_stats_table.sv -----
// Top level: per-key round-trip-time statistics table with sequencer.
//
//   Port group   Dir  Handshake                 Payload
//   in           in   in_valid_i / in_stall_o   in_data_i   (lkst_in_t)
//   out          out  out_valid_o / out_stall_i out_data_o  (lkst_out_t)
//   cfg          in   cfg_we_i                  cfg_wdata_i (enable)
//
// One transaction at a time. The key scan reads one entry per cycle from the
// entry memory until the key is found or the occupied entries run out.
// A record of a known key then waits on the serial divider of the mean update.
// Entries fill from zero upward and are never freed, so a fill count marks
// the valid entries; reset clears it at once, with no clearing pass.
// A stalled result holds in the output register until taken.
`default_nettype none

module per_key_latency_stats_table import lkst_pkg::*; #(
  parameter int unsigned ENTRIES   = 64,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire lkst_in_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output lkst_out_t      out_data_o,
  input  wire logic      cfg_we_i,
  input  wire logic      cfg_wdata_i
);

  localparam int unsigned AW    = $clog2(ENTRIES);
  localparam int unsigned CW    = $clog2(ENTRIES + 1);
  localparam int unsigned MW    = RTT_W + FRAC_BITS;
  localparam int unsigned ROW_W = KEY_W + 4 * RTT_W + TIME_W + MW;
  localparam int unsigned O_MIN  = KEY_W;
  localparam int unsigned O_MAX  = O_MIN + RTT_W;
  localparam int unsigned O_REC  = O_MAX + RTT_W;
  localparam int unsigned O_CNT  = O_REC + RTT_W;
  localparam int unsigned O_TIME = O_CNT + CNT_W;
  localparam int unsigned O_MEAN = O_TIME + TIME_W;

  state_e         state_q, state_d;
  logic           enable_q;
  logic [CW-1:0]  fill_q, fill_d;
  logic [CW-1:0]  iss_q, iss_d;
  logic           pend_q, pend_d;
  logic [AW-1:0]  pidx_q, pidx_d;
  logic [AW-1:0]  hit_idx_q, hit_idx_d;
  lkst_in_t       item_q, item_d;
  lkst_out_t      out_q, out_d;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [ROW_W-1:0] mem_wdata;
  logic             mem_re;
  logic [ROW_W-1:0] mem_rdata;

  logic             div_start;
  logic             div_done;
  logic [MW-1:0]    div_quot;

  logic [KEY_W-1:0]  r_key;
  logic [RTT_W-1:0]  r_min, r_max, r_rec;
  logic [CNT_W-1:0]  r_cnt;
  logic [TIME_W-1:0] r_time;
  logic [MW-1:0]     r_mean;

  logic [MW-1:0]     sample;
  logic              geq;
  logic [MW-1:0]     diff;
  logic [DIVR_W-1:0] divisor;
  logic [MW-1:0]     new_mean;
  logic [CNT_W-1:0]  new_cnt;
  logic [RTT_W-1:0]  new_min, new_max;
  logic [MW-1:0]     mean_src;
  logic [MW+MEAN_OW-1:0] mean_ext;
  logic              hit;
  logic              can_issue;

  assign r_key  = mem_rdata[KEY_W-1:0];
  assign r_min  = mem_rdata[O_MIN +: RTT_W];
  assign r_max  = mem_rdata[O_MAX +: RTT_W];
  assign r_rec  = mem_rdata[O_REC +: RTT_W];
  assign r_cnt  = mem_rdata[O_CNT +: CNT_W];
  assign r_time = mem_rdata[O_TIME +: TIME_W];
  assign r_mean = mem_rdata[O_MEAN +: MW];

  assign sample   = {item_q.rtt_ms, {FRAC_BITS{1'b0}}};
  assign geq      = sample >= r_mean;
  assign diff     = geq ? (sample - r_mean) : (r_mean - sample);
  assign divisor  = {1'b0, r_cnt} + DIVR_W'(1);
  assign new_mean = geq ? (r_mean + div_quot) : (r_mean - div_quot);
  assign new_cnt  = (&r_cnt) ? r_cnt : (r_cnt + CNT_W'(1));
  assign new_min  = (item_q.rtt_ms < r_min) ? item_q.rtt_ms : r_min;
  assign new_max  = (item_q.rtt_ms > r_max) ? item_q.rtt_ms : r_max;
  assign mean_ext = {{MEAN_OW{1'b0}}, mean_src};

  assign hit       = pend_q && (r_key == item_q.server_id);
  assign can_issue = iss_q < fill_q;

  lkst_store #(
    .DEPTH (ENTRIES),
    .WIDTH (ROW_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (iss_q[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  lkst_div #(
    .DW (MW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (diff),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    iss_d     = iss_q;
    pend_d    = pend_q;
    pidx_d    = pidx_q;
    hit_idx_d = hit_idx_q;
    item_d    = item_q;
    out_d     = out_q;
    mem_we    = 1'b0;
    mem_waddr = hit_idx_q;
    mem_wdata = {r_mean, r_time, r_cnt, r_rec, r_max, r_min, r_key};
    mem_re    = 1'b0;
    div_start = 1'b0;
    mean_src  = r_mean;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d = in_data_i;
          iss_d  = '0;
          pend_d = 1'b0;
          if (in_data_i.action == ACT_RECORD && !enable_q) begin
            out_d        = '0;
            out_d.status = ST_NOT_ENABLED;
            state_d      = S_OUT;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (hit) begin
          hit_idx_d = pidx_q;
          if (item_q.action == ACT_QUERY) begin
            out_d.status       = ST_OK;
            out_d.min_rtt      = r_min;
            out_d.max_rtt      = r_max;
            out_d.mean_rtt     = mean_ext[MEAN_OW-1:0];
            out_d.recent_rtt   = r_rec;
            out_d.sample_count = r_cnt;
            out_d.recent_time  = r_time;
            state_d            = S_OUT;
          end else begin
            state_d = S_PREP;
          end
        end else if (!can_issue) begin
          out_d = '0;
          if (item_q.action == ACT_QUERY) begin
            out_d.status = ST_NOT_FOUND;
          end else if (fill_q == CW'(ENTRIES)) begin
            out_d.status = ST_TABLE_FULL;
          end else begin
            // Allocate the lowest free entry with the first sample.
            mean_src           = sample;
            mem_we             = 1'b1;
            mem_waddr          = fill_q[AW-1:0];
            mem_wdata          = {sample, item_q.time_ms, CNT_W'(1), item_q.rtt_ms,
                                  item_q.rtt_ms, item_q.rtt_ms, item_q.server_id};
            fill_d             = fill_q + CW'(1);
            out_d.status       = ST_OK;
            out_d.min_rtt      = item_q.rtt_ms;
            out_d.max_rtt      = item_q.rtt_ms;
            out_d.mean_rtt     = mean_ext[MEAN_OW-1:0];
            out_d.recent_rtt   = item_q.rtt_ms;
            out_d.sample_count = CNT_W'(1);
            out_d.recent_time  = item_q.time_ms;
          end
          state_d = S_OUT;
        end else begin
          mem_re = 1'b1;
          pend_d = 1'b1;
          pidx_d = iss_q[AW-1:0];
          iss_d  = iss_q + CW'(1);
        end
      end

      S_PREP: begin
        div_start = 1'b1;
        state_d   = S_DIV;
      end

      S_DIV: begin
        if (div_done) begin
          state_d = S_UPD;
        end
      end

      S_UPD: begin
        mean_src           = new_mean;
        mem_we             = 1'b1;
        mem_wdata          = {new_mean, item_q.time_ms, new_cnt, item_q.rtt_ms,
                              new_max, new_min, r_key};
        out_d.status       = ST_OK;
        out_d.min_rtt      = new_min;
        out_d.max_rtt      = new_max;
        out_d.mean_rtt     = mean_ext[MEAN_OW-1:0];
        out_d.recent_rtt   = item_q.rtt_ms;
        out_d.sample_count = new_cnt;
        out_d.recent_time  = item_q.time_ms;
        state_d            = S_OUT;
      end

      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      enable_q <= 1'b0;
      fill_q   <= '0;
      iss_q    <= '0;
      pend_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      iss_q   <= iss_d;
      pend_q  <= pend_d;
      if (cfg_we_i) begin
        enable_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q    <= pidx_d;
    hit_idx_q <= hit_idx_d;
    item_q    <= item_d;
    out_q     <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// Testbench for the per-key latency statistics table: directed rows, then random traffic.
`timescale 1ns / 1ps

module tb_top;
  import lkst_pkg::*;

  localparam int unsigned TB_ENTRIES = 64;
  localparam int unsigned TB_FRAC    = 16;
  localparam logic [63:0] MEAN_MASK  = (64'd1 << (32 + TB_FRAC)) - 64'd1;
  localparam int unsigned POOL_SIZE  = 80;
  localparam int unsigned CHUNKS     = 6;
  localparam int unsigned CHUNK_LEN  = 150;

  typedef enum logic [1:0] {ROW_CFG, ROW_PREDICT, ROW_TYPED} row_kind_e;

  typedef struct packed {
    row_kind_e kind;
    logic      cfg_en;
    lkst_in_t  item;
    lkst_out_t exp;
  } stim_row_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  lkst_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  lkst_out_t out_data;
  logic      cfg_we    = 1'b0;
  logic      cfg_wdata = 1'b0;

  int tx_idle_pct = 16;
  int rx_idle_pct = 77;
  int mismatch_cnt = 0;

  lkst_out_t expected_stats_q[$];
  lkst_out_t oldest_stats;
  stim_row_t stim_rows[$];
  logic [31:0] key_pool [POOL_SIZE];

  // Shadow copy of the statistics table
  logic        model_enable = 1'b0;
  int          used_entries = 0;
  logic [31:0] ent_key    [TB_ENTRIES];
  logic [31:0] ent_min    [TB_ENTRIES];
  logic [31:0] ent_max    [TB_ENTRIES];
  logic [63:0] ent_mean   [TB_ENTRIES];
  logic [31:0] ent_recent [TB_ENTRIES];
  logic [31:0] ent_count  [TB_ENTRIES];
  logic [63:0] ent_time   [TB_ENTRIES];

  per_key_latency_stats_table #(
    .ENTRIES  (TB_ENTRIES),
    .FRAC_BITS(TB_FRAC)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  always #6 clk = ~clk;

  function automatic lkst_out_t empty_stats(status_e st);
    lkst_out_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

  function automatic lkst_out_t first_stats(logic [31:0] rtt, logic [63:0] tm);
    lkst_out_t r;
    r.status       = ST_OK;
    r.min_rtt      = rtt;
    r.max_rtt      = rtt;
    r.mean_rtt     = {rtt, 16'h0000};
    r.recent_rtt   = rtt;
    r.sample_count = 32'd1;
    r.recent_time  = tm;
    return r;
  endfunction

  function automatic lkst_in_t mk_rec(logic [31:0] key, logic [31:0] rtt, logic [63:0] tm);
    lkst_in_t it;
    it.action    = ACT_RECORD;
    it.server_id = key;
    it.rtt_ms    = rtt;
    it.time_ms   = tm;
    return it;
  endfunction

  function automatic lkst_in_t mk_qry(logic [31:0] key);
    lkst_in_t it;
    it = '0;
    it.action    = ACT_QUERY;
    it.server_id = key;
    return it;
  endfunction

  function automatic lkst_out_t stored_stats(int e);
    lkst_out_t r;
    r.status       = ST_OK;
    r.min_rtt      = ent_min[e];
    r.max_rtt      = ent_max[e];
    r.mean_rtt     = ent_mean[e][MEAN_OW-1:0];
    r.recent_rtt   = ent_recent[e];
    r.sample_count = ent_count[e];
    r.recent_time  = ent_time[e];
    return r;
  endfunction

  // Fold one transaction into the shadow table and return the statistics it yields
  function automatic lkst_out_t predict_stats(lkst_in_t it);
    int          e;
    int          i;
    logic [63:0] sample;
    logic [63:0] divisor;
    e = -1;
    for (i = 0; i < used_entries; i++)
      if (e < 0 && ent_key[i] == it.server_id) e = i;
    if (it.action == ACT_QUERY) begin
      if (e < 0) return empty_stats(ST_NOT_FOUND);
      return stored_stats(e);
    end
    if (!model_enable) return empty_stats(ST_NOT_ENABLED);
    sample = (64'(it.rtt_ms) << TB_FRAC) & MEAN_MASK;
    if (e < 0) begin
      if (used_entries == TB_ENTRIES) return empty_stats(ST_TABLE_FULL);
      e = used_entries;
      used_entries++;
      ent_key[e]   = it.server_id;
      ent_min[e]   = it.rtt_ms;
      ent_max[e]   = it.rtt_ms;
      ent_mean[e]  = sample;
      ent_count[e] = '0;
    end else begin
      divisor = 64'(ent_count[e]) + 64'd1;
      if (it.rtt_ms < ent_min[e]) ent_min[e] = it.rtt_ms;
      if (it.rtt_ms > ent_max[e]) ent_max[e] = it.rtt_ms;
      if (sample >= ent_mean[e])
        ent_mean[e] = ent_mean[e] + (sample - ent_mean[e]) / divisor;
      else
        ent_mean[e] = ent_mean[e] - (ent_mean[e] - sample) / divisor;
      ent_mean[e] = ent_mean[e] & MEAN_MASK;
    end
    ent_recent[e] = it.rtt_ms;
    if (ent_count[e] != 32'hFFFF_FFFF) ent_count[e] = ent_count[e] + 32'd1;
    ent_time[e] = it.time_ms;
    return stored_stats(e);
  endfunction

  task automatic add_row(row_kind_e kind, logic en, lkst_in_t it, lkst_out_t exp);
    stim_row_t row;
    row.kind   = kind;
    row.cfg_en = en;
    row.item   = it;
    row.exp    = exp;
    stim_rows.push_back(row);
  endtask

  // Present one transaction and record its expected statistics once accepted
  task automatic send_item(lkst_in_t it, bit typed, lkst_out_t typed_exp);
    int        gap;
    lkst_out_t pred;
    gap = 0;
    while ($urandom_range(0, 99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = predict_stats(it);
    expected_stats_q.push_back(typed ? typed_exp : pred);
  endtask

  task automatic write_enable(logic en);
    // Drop the sender first so the last transaction is not taken twice
    in_valid <= 1'b0;
    while (expected_stats_q.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= en;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_enable = en;
  endtask

  function automatic lkst_in_t rand_item();
    lkst_in_t    it;
    logic [31:0] key;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 45 && used_entries > 0)
      key = ent_key[$urandom_range(0, used_entries - 1)];
    else if (r < 90)
      key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    else
      key = $urandom;
    it = mk_rec(key, 32'd0, {$urandom, $urandom});
    case ($urandom_range(0, 9))
      0: it.rtt_ms = 32'd0;
      1: it.rtt_ms = 32'hFFFF_FFFF;
      2, 3, 4, 5: it.rtt_ms = 32'd1000 + 32'($urandom_range(0, 50));
      default: it.rtt_ms = $urandom;
    endcase
    if ($urandom_range(0, 99) < 30) it.action = ACT_QUERY;
    return it;
  endfunction

  task automatic compare_field(string name, logic [63:0] exp, logic [63:0] act);
    if (exp !== act) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("mismatch %s: expected %h actual %h", name, exp, act);
    end
  endtask

  always @(posedge clk) begin
    if ($urandom_range(0, 99) < rx_idle_pct) out_stall <= 1'b1;
    else out_stall <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_stats_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result: actual %h", out_data);
      end else begin
        oldest_stats = expected_stats_q.pop_front();
        compare_field("status", 64'(oldest_stats.status), 64'(out_data.status));
        compare_field("min_rtt", 64'(oldest_stats.min_rtt), 64'(out_data.min_rtt));
        compare_field("max_rtt", 64'(oldest_stats.max_rtt), 64'(out_data.max_rtt));
        compare_field("mean_rtt", 64'(oldest_stats.mean_rtt), 64'(out_data.mean_rtt));
        compare_field("recent_rtt", 64'(oldest_stats.recent_rtt),
                      64'(out_data.recent_rtt));
        compare_field("sample_count", 64'(oldest_stats.sample_count),
                      64'(out_data.sample_count));
        compare_field("recent_time", oldest_stats.recent_time, out_data.recent_time);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("FAIL per_key_latency_stats_table");
    $finish;
  end

  initial begin
    int        i;
    int        c;
    stim_row_t row;

    for (i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    // Disabled after reset: records refused, queries answered
    add_row(ROW_TYPED, 1'b0, mk_qry(32'h0), empty_stats(ST_NOT_FOUND));
    add_row(ROW_TYPED, 1'b0, mk_rec(32'h1234_5678, 32'd5, 64'd1),
            empty_stats(ST_NOT_ENABLED));
    add_row(ROW_TYPED, 1'b0, mk_qry(32'h1234_5678), empty_stats(ST_NOT_FOUND));
    add_row(ROW_CFG, 1'b1, '0, '0);
    add_row(ROW_TYPED, 1'b0, mk_rec(32'hFFFF_FFFF, 32'hFFFF_FFFF, '1),
            first_stats(32'hFFFF_FFFF, '1));
    add_row(ROW_PREDICT, 1'b0, mk_rec(32'hFFFF_FFFF, 32'd0, 64'd0), '0);
    add_row(ROW_PREDICT, 1'b0, mk_rec(32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd5), '0);
    add_row(ROW_PREDICT, 1'b0, mk_qry(32'hFFFF_FFFF), '0);
    add_row(ROW_TYPED, 1'b0, mk_rec(32'h0, 32'd0, 64'd0), first_stats(32'd0, 64'd0));
    add_row(ROW_PREDICT, 1'b0, mk_rec(32'h0, 32'd1, 64'd2), '0);
    add_row(ROW_PREDICT, 1'b0, mk_rec(32'h0, 32'd0, 64'd3), '0);
    add_row(ROW_TYPED, 1'b0, mk_qry(32'h1), empty_stats(ST_NOT_FOUND));
    add_row(ROW_TYPED, 1'b0, mk_rec(32'hA5A5_A5A5, 32'd100, 64'h8000_0000_0000_0000),
            first_stats(32'd100, 64'h8000_0000_0000_0000));
    add_row(ROW_PREDICT, 1'b0, mk_rec(32'hA5A5_A5A5, 32'd103, 64'd7), '0);
    add_row(ROW_PREDICT, 1'b0, mk_rec(32'hA5A5_A5A5, 32'd7, 64'd8), '0);
    add_row(ROW_CFG, 1'b0, '0, '0);
    add_row(ROW_TYPED, 1'b0, mk_rec(32'hA5A5_A5A5, 32'd9, 64'd9),
            empty_stats(ST_NOT_ENABLED));
    add_row(ROW_PREDICT, 1'b0, mk_qry(32'hA5A5_A5A5), '0);
    add_row(ROW_CFG, 1'b1, '0, '0);
    add_row(ROW_TYPED, 1'b0, mk_qry(32'h5A5A_5A5A), empty_stats(ST_NOT_FOUND));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      if (row.kind == ROW_CFG) write_enable(row.cfg_en);
      else send_item(row.item, row.kind == ROW_TYPED, row.exp);
    end

    // Random traffic: sender-light idling, then receiver-light, then none
    for (c = 0; c < CHUNKS; c++) begin
      write_enable(c != 2);
      if (c < 2) begin
        tx_idle_pct = 16;
        rx_idle_pct = 77;
      end else if (c < 4) begin
        tx_idle_pct = 77;
        rx_idle_pct = 16;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      for (i = 0; i < CHUNK_LEN; i++) send_item(rand_item(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    // Drain, then give any stray result time to show up
    while (expected_stats_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("PASS per_key_latency_stats_table");
    end else begin
      $display("FAIL per_key_latency_stats_table");
    end
    $finish;
  end

endmodule
